[hdl/sit_pkg.sv]
package sit_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic shift;
        logic occupied;
    } t_cell_cmd;

endpackage

[hdl/sorted_insert_table.sv]
// sorted insert table: keeps up to DEPTH signed entries in ascending order
// input channel (i_in_valid / o_in_stall) carries opcode, value and index;
// opcode insert places the value before any equal entries, read returns the
// entry at index, clear empties the table
// output channel (o_out_valid / i_out_stall) carries exactly one result item
// per input item: position, element, count and status
// status flags a dropped insert into a full table or a read at or beyond count
// the result is registered in the output register, so o_out_valid rises in
// the cycle after accept; one item per cycle is sustained while the receiver
// does not stall, since every cell compares and shifts in the same cycle
// when the receiver stalls, the result holds and the input stalls until
// the output register is taken
// synchronous active-low reset empties the table and drops any pending result;
// entries themselves are not cleared, reads are gated by the count
module sorted_insert_table #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [$clog2(DEPTH)-1:0]     i_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [$clog2(DEPTH)-1:0]     o_position,
    output logic signed [VALUE_BITS-1:0] o_element,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [1:0]                   o_status
);
    import sit_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [VALUE_BITS-1:0] w_entry [DEPTH];
    logic                         w_less  [DEPTH];
    t_cell_cmd                    w_cmd   [DEPTH];

    logic                         r_out_valid;
    logic [CNT_W-1:0]             r_fill;
    logic [CNT_W-1:0]             n_fill;
    logic [IDX_W-1:0]             r_position;
    logic [IDX_W-1:0]             n_position;
    logic signed [VALUE_BITS-1:0] r_element;
    logic signed [VALUE_BITS-1:0] n_element;
    logic [1:0]                   r_status;
    logic [1:0]                   n_status;

    logic             accept;
    logic             full;
    logic             do_insert;
    logic [IDX_W-1:0] slot;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_fill == CNT_W'(DEPTH));
    assign do_insert  = accept && (i_opcode == OP_INSERT) && !full;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_cmd[g].shift    = do_insert;
        assign w_cmd[g].occupied = (CNT_W'(g) < r_fill);
        if (g == 0) begin : g_first
            sit_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd[g]),
                .i_value      (i_value),
                .i_left_entry (i_value),
                .i_left_less  (1'b1),
                .o_entry      (w_entry[g]),
                .o_less       (w_less[g])
            );
        end else begin : g_rest
            sit_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd[g]),
                .i_value      (i_value),
                .i_left_entry (w_entry[g-1]),
                .i_left_less  (w_less[g-1]),
                .o_entry      (w_entry[g]),
                .o_less       (w_less[g])
            );
        end
    end

    // insert slot: the cell whose left neighbor is smaller and itself is not
    always_comb begin
        slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (((i == 0) || w_less[(i == 0) ? 0 : i - 1]) && !w_less[i]) begin
                slot = slot | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_fill     = r_fill;
        n_position = '0;
        n_element  = '0;
        n_status   = ST_OK;
        unique case (i_opcode)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_position = slot;
                    n_fill     = r_fill + CNT_W'(1);
                end
            end
            OP_READ: begin
                if ({1'b0, i_index} >= (IDX_W + 1)'(r_fill)) begin
                    n_status = ST_RANGE;
                end else begin
                    n_element = w_entry[i_index];
                end
            end
            OP_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_fill      <= n_fill;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_position <= n_position;
            r_element  <= n_element;
            r_status   <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_element   = r_element;
    assign o_count     = r_fill;
    assign o_status    = r_status;

endmodule

[hdl/sit_cell.sv]
module sit_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  sit_pkg::t_cell_cmd           i_cmd,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic signed [VALUE_BITS-1:0] i_left_entry,
    input  logic                         i_left_less,
    output logic signed [VALUE_BITS-1:0] o_entry,
    output logic                         o_less
);
    import sit_pkg::*;

    logic signed [VALUE_BITS-1:0] r_entry;
    logic signed [VALUE_BITS-1:0] n_entry;

    assign o_less  = i_cmd.occupied && (r_entry < i_value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift && !o_less) begin
            if (i_left_less) begin
                n_entry = i_value;
            end else begin
                n_entry = i_left_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
